### hw/rtl/audio_noise_gate_macros.svh
// Assertion helpers shared by the noise gate RTL.
// Both sample on the rising edge of clk and are off while arst_n is low.
`ifndef AUDIO_NOISE_GATE_MACROS_SVH
`define AUDIO_NOISE_GATE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ANG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ANG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/ang_pkg.sv
`default_nettype none

package ang_pkg;

	localparam int CHANNELS    = 8;
	localparam int SAMPLE_BITS = 24;

	localparam int CHN_W  = 3;
	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ENV_W  = SAMPLE_BITS - 1;
	localparam int GAIN_W = 17;
	localparam int COEF_W = 16;
	localparam int FRAC   = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = (ENV_W > COEF_W) ? ENV_W : COEF_W;

	// shared multiplier operands, both signed
	localparam int MA_W   = (SAMPLE_BITS + 1 > GAIN_W + 1) ? SAMPLE_BITS + 1 : GAIN_W + 1;
	localparam int MB_W   = GAIN_W + 1;
	localparam int PROD_W = MA_W + MB_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int RND_W  = SUM_W - FRAC;

	localparam int ROUND_HALF = 32768;

	typedef logic        [SAMPLE_BITS-1:0] sample_t;
	typedef logic        [ENV_W-1:0]       env_t;
	typedef logic        [GAIN_W-1:0]      gain_t;
	typedef logic        [COEF_W-1:0]      coef_t;
	typedef logic        [CH_W-1:0]        chan_t;
	typedef logic signed [MA_W-1:0]        mul_a_t;
	typedef logic signed [MB_W-1:0]        mul_b_t;
	typedef logic signed [PROD_W-1:0]      prod_t;
	typedef logic signed [SUM_W-1:0]       sum_t;
	typedef logic        [RND_W-1:0]       rnd_t;

	localparam gain_t   UNITY_GAIN = gain_t'(65536);
	localparam gain_t   FLOOR_GAIN = gain_t'(3277);
	localparam gain_t   GAIN_MAX   = '1;
	localparam env_t    ENV_MAX    = '1;
	localparam sample_t SMAX       = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SMIN       = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	localparam env_t  RST_THRESHOLD = env_t'(47171);
	localparam coef_t RST_ENV_COEF  = coef_t'(65263);
	localparam coef_t RST_ATK_COEF  = coef_t'(64856);
	localparam coef_t RST_REL_COEF  = coef_t'(65525);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GATE_ENABLE    = 3'd0,
		CFG_OPEN_THRESHOLD = 3'd1,
		CFG_ENVELOPE_COEFF = 3'd2,
		CFG_ATTACK_COEFF   = 3'd3,
		CFG_RELEASE_COEFF  = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENV_MUL,
		ST_ENV_SUM,
		ST_GAIN_MUL,
		ST_GAIN_SUM,
		ST_OUT_MUL,
		ST_OUT_RND
	} state_t;

	typedef enum logic [1:0] {
		OP_ENV,
		OP_GAIN,
		OP_OUT
	} mul_op_t;

	typedef struct packed {
		logic    ld_in;
		logic    mul_en;
		mul_op_t op;
		logic    upd_env;
		logic    upd_gain;
		logic    ld_out;
	} cmd_t;

	// Fold the channel field into range by repeated subtraction.
	function automatic chan_t chan_wrap(input logic [CHN_W-1:0] ch);
		logic [CHN_W-1:0] v;
		v = ch;
		for (int i = 0; i < (1 << CHN_W); i++) begin
			if (int'(v) >= CHANNELS) begin
				v = v - CHN_W'(CHANNELS);
			end
		end
		return chan_t'(v);
	endfunction

endpackage

`default_nettype wire

### hw/rtl/ang_ctrl.sv
`default_nettype none

module ang_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output      logic          in_stall,
	output      logic          out_valid,
	input  wire logic          out_stall,
	output      ang_pkg::cmd_t cmd
);

	ang_pkg::state_t state_q;
	ang_pkg::state_t state_d;
	logic            out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ang_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = ang_pkg::ST_ENV_MUL;
				end
			end
			ang_pkg::ST_ENV_MUL:  state_d = ang_pkg::ST_ENV_SUM;
			ang_pkg::ST_ENV_SUM:  state_d = ang_pkg::ST_GAIN_MUL;
			ang_pkg::ST_GAIN_MUL: state_d = ang_pkg::ST_GAIN_SUM;
			ang_pkg::ST_GAIN_SUM: state_d = ang_pkg::ST_OUT_MUL;
			ang_pkg::ST_OUT_MUL:  state_d = ang_pkg::ST_OUT_RND;
			ang_pkg::ST_OUT_RND: begin
				// hold until the output register is free
				if (!out_valid_q || !out_stall) begin
					state_d = ang_pkg::ST_IDLE;
				end
			end
			default: state_d = ang_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.op = ang_pkg::OP_ENV;
		case (state_q)
			ang_pkg::ST_IDLE: begin
				cmd.ld_in = in_valid;
			end
			ang_pkg::ST_ENV_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.op     = ang_pkg::OP_ENV;
			end
			ang_pkg::ST_ENV_SUM: begin
				cmd.upd_env = 1'b1;
			end
			ang_pkg::ST_GAIN_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.op     = ang_pkg::OP_GAIN;
			end
			ang_pkg::ST_GAIN_SUM: begin
				cmd.upd_gain = 1'b1;
			end
			ang_pkg::ST_OUT_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.op     = ang_pkg::OP_OUT;
			end
			ang_pkg::ST_OUT_RND: begin
				cmd.ld_out = !out_valid_q || !out_stall;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign in_stall  = (state_q != ang_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ang_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/ang_dp.sv
`default_nettype none

module ang_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire ang_pkg::cmd_t                      cmd,
	input  wire logic                               cfg_we,
	input  wire logic [ang_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ang_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic [ang_pkg::CHN_W-1:0]          channel,
	input  wire logic signed [ang_pkg::SAMPLE_BITS-1:0] sample_in,
	output      logic signed [ang_pkg::SAMPLE_BITS-1:0] sample_out,
	output      logic [ang_pkg::GAIN_W-1:0]         gain_now,
	output      logic                               gate_open
);

	// configuration
	logic                gate_en_q;
	ang_pkg::env_t       thr_q;
	ang_pkg::coef_t      env_coef_q;
	ang_pkg::coef_t      atk_coef_q;
	ang_pkg::coef_t      rel_coef_q;

	// per-channel state
	ang_pkg::env_t       env_mem [ang_pkg::CHANNELS];
	ang_pkg::gain_t      gain_mem [ang_pkg::CHANNELS];

	// item registers
	ang_pkg::chan_t      ch_q;
	logic                neg_q;
	ang_pkg::sample_t    mag_q;
	ang_pkg::env_t       amag_q;
	ang_pkg::env_t       env_old_q;
	ang_pkg::gain_t      g_old_q;
	ang_pkg::env_t       env_q;
	ang_pkg::gain_t      g_q;
	ang_pkg::prod_t      prod_q;

	// output registers
	ang_pkg::sample_t    sout_q;
	ang_pkg::gain_t      gout_q;
	logic                open_out_q;

	ang_pkg::sample_t    mag_c;
	ang_pkg::env_t       amag_c;
	logic signed [ang_pkg::ENV_W:0]  diff_env;
	logic signed [ang_pkg::GAIN_W:0] diff_g;
	logic                open_c;
	ang_pkg::gain_t      target_c;
	ang_pkg::coef_t      coef_c;
	ang_pkg::mul_a_t     mul_a;
	ang_pkg::mul_b_t     mul_b;
	ang_pkg::sum_t       env_sum;
	ang_pkg::sum_t       g_sum;
	ang_pkg::sum_t       r_sum;
	ang_pkg::rnd_t       r_c;
	ang_pkg::env_t       env_new;
	ang_pkg::gain_t      g_new;
	ang_pkg::sample_t    sout_c;

	// magnitude; the most negative sample gives 2^(N-1), clipped for the envelope
	always_comb begin
		mag_c  = sample_in[ang_pkg::SAMPLE_BITS-1] ? ang_pkg::sample_t'(-sample_in)
		                                            : ang_pkg::sample_t'(sample_in);
		amag_c = mag_c[ang_pkg::SAMPLE_BITS-1] ? ang_pkg::ENV_MAX
		                                       : mag_c[ang_pkg::ENV_W-1:0];
	end

	always_comb begin
		open_c   = !gate_en_q || (env_q > thr_q);
		target_c = open_c ? ang_pkg::UNITY_GAIN : ang_pkg::FLOOR_GAIN;
		coef_c   = (target_c > g_old_q) ? atk_coef_q : rel_coef_q;
		diff_env = $signed({1'b0, env_old_q}) - $signed({1'b0, amag_q});
		diff_g   = $signed({1'b0, g_old_q}) - $signed({1'b0, target_c});
	end

	// one-pole step as x + (old - x) * c, so one product per update
	always_comb begin
		case (cmd.op)
			ang_pkg::OP_ENV: begin
				mul_a = ang_pkg::mul_a_t'(diff_env);
				mul_b = ang_pkg::mul_b_t'(env_coef_q);
			end
			ang_pkg::OP_GAIN: begin
				mul_a = ang_pkg::mul_a_t'(diff_g);
				mul_b = ang_pkg::mul_b_t'(coef_c);
			end
			ang_pkg::OP_OUT: begin
				mul_a = ang_pkg::mul_a_t'(mag_q);
				mul_b = ang_pkg::mul_b_t'(g_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		env_sum = ang_pkg::sum_t'(prod_q)
		        + ang_pkg::sum_t'({amag_q, {ang_pkg::FRAC{1'b0}}})
		        + ang_pkg::sum_t'(ang_pkg::ROUND_HALF);
		if (env_sum[ang_pkg::SUM_W-1]) begin
			env_new = '0;
		end else if (|env_sum[ang_pkg::SUM_W-2:ang_pkg::FRAC+ang_pkg::ENV_W]) begin
			env_new = ang_pkg::ENV_MAX;
		end else begin
			env_new = env_sum[ang_pkg::FRAC+ang_pkg::ENV_W-1:ang_pkg::FRAC];
		end

		g_sum = ang_pkg::sum_t'(prod_q)
		      + ang_pkg::sum_t'({target_c, {ang_pkg::FRAC{1'b0}}})
		      + ang_pkg::sum_t'(ang_pkg::ROUND_HALF);
		if (g_sum[ang_pkg::SUM_W-1]) begin
			g_new = '0;
		end else if (|g_sum[ang_pkg::SUM_W-2:ang_pkg::FRAC+ang_pkg::GAIN_W]) begin
			g_new = ang_pkg::GAIN_MAX;
		end else begin
			g_new = g_sum[ang_pkg::FRAC+ang_pkg::GAIN_W-1:ang_pkg::FRAC];
		end

		// round half away from zero on the magnitude, then restore sign and clip
		r_sum = ang_pkg::sum_t'(prod_q) + ang_pkg::sum_t'(ang_pkg::ROUND_HALF);
		r_c   = r_sum[ang_pkg::SUM_W-1:ang_pkg::FRAC];
		if (neg_q) begin
			if (r_c > ang_pkg::rnd_t'(ang_pkg::SMIN)) begin
				sout_c = ang_pkg::SMIN;
			end else begin
				sout_c = ~r_c[ang_pkg::SAMPLE_BITS-1:0] + ang_pkg::sample_t'(1);
			end
		end else begin
			if (r_c > ang_pkg::rnd_t'(ang_pkg::SMAX)) begin
				sout_c = ang_pkg::SMAX;
			end else begin
				sout_c = r_c[ang_pkg::SAMPLE_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_en_q  <= 1'b1;
			thr_q      <= ang_pkg::RST_THRESHOLD;
			env_coef_q <= ang_pkg::RST_ENV_COEF;
			atk_coef_q <= ang_pkg::RST_ATK_COEF;
			rel_coef_q <= ang_pkg::RST_REL_COEF;
			for (int i = 0; i < ang_pkg::CHANNELS; i++) begin
				env_mem[i]  <= '0;
				gain_mem[i] <= ang_pkg::UNITY_GAIN;
			end
		end else begin
			if (cfg_we) begin
				case (ang_pkg::cfg_reg_t'(cfg_index))
					ang_pkg::CFG_GATE_ENABLE:    gate_en_q  <= cfg_data[0];
					ang_pkg::CFG_OPEN_THRESHOLD: thr_q      <= cfg_data[ang_pkg::ENV_W-1:0];
					ang_pkg::CFG_ENVELOPE_COEFF: env_coef_q <= cfg_data[ang_pkg::COEF_W-1:0];
					ang_pkg::CFG_ATTACK_COEFF:   atk_coef_q <= cfg_data[ang_pkg::COEF_W-1:0];
					ang_pkg::CFG_RELEASE_COEFF:  rel_coef_q <= cfg_data[ang_pkg::COEF_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.upd_env) begin
				env_mem[ch_q] <= env_new;
			end
			if (cmd.upd_gain) begin
				gain_mem[ch_q] <= g_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			ch_q      <= ang_pkg::chan_wrap(channel);
			neg_q     <= sample_in[ang_pkg::SAMPLE_BITS-1];
			mag_q     <= mag_c;
			amag_q    <= amag_c;
			env_old_q <= env_mem[ang_pkg::chan_wrap(channel)];
			g_old_q   <= gain_mem[ang_pkg::chan_wrap(channel)];
		end
		if (cmd.mul_en) begin
			// full-width signed product: operands extend to the register width
			prod_q <= mul_a * mul_b;
		end
		if (cmd.upd_env) begin
			env_q <= env_new;
		end
		if (cmd.upd_gain) begin
			g_q <= g_new;
		end
		if (cmd.ld_out) begin
			sout_q     <= sout_c;
			gout_q     <= g_q;
			open_out_q <= open_c;
		end
	end

	assign sample_out = $signed(sout_q);
	assign gain_now   = gout_q;
	assign gate_open  = open_out_q;

endmodule

`default_nettype wire

### hw/rtl/audio_noise_gate.sv
// out_valid is registered when the rounding step loads the output register, which an
// output stall can hold off. A new sample is taken only from idle, and all three
// products of a sample go through one shared 25x18 multiplier, one after another.
// A finished result sits in the output register while the next sample is taken.
// Reset (arst_n low, asynchronous): configuration registers return to their defaults, every
// channel envelope clears to zero and every channel gain returns to unity.
`default_nettype none

`include "audio_noise_gate_macros.svh"

module audio_noise_gate (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,

	// sample input channel
	input  wire logic                                   in_valid,
	output      logic                                   in_stall,
	input  wire logic [ang_pkg::CHN_W-1:0]              channel,
	input  wire logic signed [ang_pkg::SAMPLE_BITS-1:0] sample_in,

	// result channel
	output      logic                                   out_valid,
	input  wire logic                                   out_stall,
	output      logic signed [ang_pkg::SAMPLE_BITS-1:0] sample_out,
	output      logic [ang_pkg::GAIN_W-1:0]             gain_now,
	output      logic                                   gate_open,

	// register write channel
	input  wire logic                                   cfg_valid,
	output      logic                                   cfg_ready,
	input  wire logic [ang_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [ang_pkg::CFG_DATA_W-1:0]         cfg_data
);

	ang_pkg::cmd_t cmd;

	// cfg_ready is tied high, so the write channel never waits.
	// Software writes are to be made only while the gate is idle; the block itself does not enforce this.
	assign cfg_ready = 1'b1;

	// The controller walks each sample through:
	//   envelope product -> envelope update -> gain product -> gain update
	//   -> output product -> rounding into the output register.
	// It holds in the last step while the output register still owes a transfer.
	ang_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// The datapath owns the registers, the per-channel envelope and gain state,
	// the shared multiplier and the rounding and clipping logic.
	// Each one-pole update is computed as x + (old - x) * c with round-to-nearest,
	// which matches x*(1-c) + old*c bit for bit.
	ang_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.channel    (channel),
		.sample_in  (sample_in),
		.sample_out (sample_out),
		.gain_now   (gain_now),
		.gate_open  (gate_open)
	);

	// The controller leaves idle when it takes a sample, so the input must stall right after a transfer.
	`ANG_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "input taken while busy")

	// Gain only blends between the floor and unity, so it never exceeds unity.
	`ANG_ASSERT_NOW(a_gain_range, out_valid, gain_now <= ang_pkg::UNITY_GAIN, "gain above unity")

endmodule

`default_nettype wire
